@@ sv/held_note_slot_table_top_defines.svh @@
// Assertion macros for the held note slot table RTL.
// Included by hnst_back, which carries the concurrent checks; define NO_ASSERTIONS to drop them.
`ifndef HELD_NOTE_SLOT_TABLE_TOP_DEFINES_SVH
`define HELD_NOTE_SLOT_TABLE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset
`define HNST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked out of reset
`define HNST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HNST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define HNST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/hnst_pkg.sv @@
// Shared types and constants for the held note slot table.
// No dependencies; used by hnst_front, hnst_back and the top level.
`default_nettype none

package hnst_pkg;

  localparam int          DEFAULT_SLOTS    = 128;
  localparam logic [15:0] DEFAULT_DURATION = 16'd3000;
  localparam int          CMD_QUEUE_DEPTH  = 2;

  // Event codes on the action port
  localparam logic [2:0] ACT_NOTE_ON  = 3'd0;
  localparam logic [2:0] ACT_NOTE_OFF = 3'd1;
  localparam logic [2:0] ACT_ALL_OFF  = 3'd2;
  localparam logic [2:0] ACT_CHAN_OFF = 3'd3;
  localparam logic [2:0] ACT_EXPIRE   = 3'd4;

  // Classified operation handed from front to back
  typedef enum logic [5:0] {
    OP_NOTE_ON  = 6'b000001,
    OP_NOTE_OFF = 6'b000010,
    OP_ALL_OFF  = 6'b000100,
    OP_CHAN_OFF = 6'b001000,
    OP_EXPIRE   = 6'b010000,
    OP_NONE     = 6'b100000
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [31:0] now_ms;
  } cmd_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic        active;
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [31:0] start_ms;
    logic [31:0] end_ms;
  } entry_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

@@ sv/hnst_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hnst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/hnst_front.sv @@
// Front end: accepts events, classifies the action and queues commands for the back end.
// Depends on hnst_pkg.
`default_nettype none

module hnst_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output      logic                  full,
  input  wire logic [2:0]            action,
  input  wire logic [7:0]            port,
  input  wire logic [3:0]            channel,
  input  wire logic [6:0]            note_number,
  input  wire logic [31:0]           now_ms,
  input  wire hnst_pkg::back_status_t status,
  output      logic                  cmd_valid,
  output      hnst_pkg::cmd_t        cmd,
  input  wire logic                  cmd_pop
);

  localparam int QD   = hnst_pkg::CMD_QUEUE_DEPTH;
  localparam int QI_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int QC_W = $clog2(QD + 1);
  localparam logic [QI_W-1:0] Q_LAST = QI_W'(QD - 1);
  localparam logic [QC_W-1:0] Q_FULL = QC_W'(QD);

  hnst_pkg::cmd_t  q [QD];
  logic [QI_W-1:0] wr_ptr;
  logic [QI_W-1:0] rd_ptr;
  logic [QC_W-1:0] q_cnt;
  logic [QC_W-1:0] q_cnt_next;
  logic            accept;
  hnst_pkg::op_t   op_dec;
  hnst_pkg::cmd_t  new_cmd;

  // Classify the action code
  always_comb begin
    case (action)
      hnst_pkg::ACT_NOTE_ON:  op_dec = hnst_pkg::OP_NOTE_ON;
      hnst_pkg::ACT_NOTE_OFF: op_dec = hnst_pkg::OP_NOTE_OFF;
      hnst_pkg::ACT_ALL_OFF:  op_dec = hnst_pkg::OP_ALL_OFF;
      hnst_pkg::ACT_CHAN_OFF: op_dec = hnst_pkg::OP_CHAN_OFF;
      hnst_pkg::ACT_EXPIRE:   op_dec = hnst_pkg::OP_EXPIRE;
      default:                op_dec = hnst_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    new_cmd.op      = op_dec;
    new_cmd.port    = port;
    new_cmd.channel = channel;
    new_cmd.note    = note_number;
    new_cmd.now_ms  = now_ms;
  end

  // Hold off input while the queue is full or the table is being cleared
  assign full      = (q_cnt == Q_FULL) || status.clearing;
  assign accept    = push && !full;
  assign cmd_valid = (q_cnt != '0);
  assign cmd       = q[rd_ptr];

  // Store accepted beats
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  // Track occupancy
  always_comb begin
    case ({accept, cmd_pop})
      2'b10:   q_cnt_next = q_cnt + QC_W'(1);
      2'b01:   q_cnt_next = q_cnt - QC_W'(1);
      default: q_cnt_next = q_cnt;
    endcase
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      q_cnt <= q_cnt_next;
      if (accept) begin
        wr_ptr <= (wr_ptr == Q_LAST) ? '0 : wr_ptr + QI_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == Q_LAST) ? '0 : rd_ptr + QI_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/hnst_back.sv @@
// Back end: sweeps the slot table in RAM for each known command and builds the result.
// Depends on hnst_pkg, hnst_ram and the assertion macro header.
`default_nettype none
`include "held_note_slot_table_top_defines.svh"

module hnst_back #(
  parameter int NOTE_SLOTS = hnst_pkg::DEFAULT_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [15:0]           cfg_data,
  input  wire logic                  cmd_valid,
  input  wire hnst_pkg::cmd_t        cmd,
  output      logic                  cmd_pop,
  output      hnst_pkg::back_status_t status,
  output      logic                  empty,
  input  wire logic                  pop,
  output      logic [6:0]            slot,
  output      logic                  found,
  output      logic                  stolen,
  output      logic [7:0]            closed_count
);

  localparam int IDX_W   = $clog2(NOTE_SLOTS);
  localparam int CNT_W   = $clog2(NOTE_SLOTS + 1);
  localparam int ENTRY_W = $bits(hnst_pkg::entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NOTE_SLOTS - 1);
  localparam logic [CNT_W-1:0] SWEEP_END = CNT_W'(NOTE_SLOTS);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_COMMIT = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [15:0]      duration;
  hnst_pkg::cmd_t   cur;
  logic [CNT_W-1:0] iss_cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             old_seen;
  logic [IDX_W-1:0] old_idx;
  logic [31:0]      old_start;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [7:0]       close_cnt;
  logic             res_valid;
  logic [6:0]       res_slot;
  logic             res_found;
  logic             res_stolen;
  logic [7:0]       res_count;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  hnst_pkg::entry_t e;
  hnst_pkg::entry_t wb;
  hnst_pkg::entry_t fresh;
  logic             held;
  logic             same_chan;
  logic             key_match;
  logic [31:0]      age;
  logic             stale;
  logic             close;
  logic             free_up;
  logic             take_free;
  logic             older;
  logic [IDX_W-1:0] slot_pick;
  logic [IDX_W-1:0] slot_src;
  logic [IDX_W+6:0] slot_wide;
  logic             load_res;

  // Slot table storage
  hnst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Classify the entry returned by the read port
  always_comb begin
    e         = hnst_pkg::entry_t'(ram_rdata);
    held      = e.active && (e.end_ms == '0);
    same_chan = (e.port == cur.port) && (e.channel == cur.channel);
    key_match = same_chan && (e.note == cur.note);
    age       = cur.now_ms - e.end_ms;
    stale     = e.active && (e.end_ms != '0) && (age > {16'd0, duration});
  end

  // Decide what the current command does to this entry
  always_comb begin
    close   = 1'b0;
    free_up = 1'b0;
    case (cur.op)
      hnst_pkg::OP_NOTE_ON:  close   = held && key_match;
      hnst_pkg::OP_NOTE_OFF: close   = held && key_match && !hit;
      hnst_pkg::OP_ALL_OFF:  close   = held;
      hnst_pkg::OP_CHAN_OFF: close   = held && same_chan;
      hnst_pkg::OP_EXPIRE:   free_up = stale;
      default: ;
    endcase
    close   = close && chk_valid;
    free_up = free_up && chk_valid;
    take_free = chk_valid && (cur.op == hnst_pkg::OP_NOTE_ON) && !free_found &&
                (!e.active || stale);
    older = chk_valid && (cur.op == hnst_pkg::OP_NOTE_ON) && e.active &&
            (!old_seen || (e.start_ms < old_start));
    wb = e;
    if (close) begin
      wb.end_ms = cur.now_ms;
    end
    if (free_up) begin
      wb.active = 1'b0;
    end
  end

  // Build the new entry for note on
  always_comb begin
    fresh.active   = 1'b1;
    fresh.port     = cur.port;
    fresh.channel  = cur.channel;
    fresh.note     = cur.note;
    fresh.start_ms = cur.now_ms;
    fresh.end_ms   = '0;
  end

  assign slot_pick = free_found ? free_idx : old_idx;

  // Drive the RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = ENTRY_W'(wb);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = iss_cnt[IDX_W-1:0];
        ram_wdata = '0;
      end
      ST_SWEEP: begin
        ram_we = close || free_up;
      end
      ST_COMMIT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_pick;
        ram_wdata = ENTRY_W'(fresh);
      end
      default: ;
    endcase
  end

  assign ram_re    = (state == ST_SWEEP) && (iss_cnt != SWEEP_END);
  assign ram_raddr = iss_cnt[IDX_W-1:0];

  assign cmd_pop         = (state == ST_IDLE) && cmd_valid;
  assign status.clearing = (state == ST_CLEAR);
  assign load_res        = (state == ST_DONE) && (!res_valid || pop);

  // Sequence the states
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (iss_cnt[IDX_W-1:0] == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd.op == hnst_pkg::OP_NONE) ? ST_DONE : ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (chk_valid && (chk_idx == LAST_IDX)) begin
          state_next = (cur.op == hnst_pkg::OP_NOTE_ON) ? ST_COMMIT : ST_DONE;
        end
      end
      ST_COMMIT: state_next = ST_DONE;
      ST_DONE: begin
        if (load_res) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Hold the display duration register
  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= hnst_pkg::DEFAULT_DURATION;
    end else if (cfg_write) begin
      duration <= cfg_data;
    end
  end

  // Advance state, read issue and the check stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      iss_cnt   <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= ram_re;
      if (state == ST_IDLE) begin
        iss_cnt <= '0;
      end else if ((state == ST_CLEAR) || ram_re) begin
        iss_cnt <= iss_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      chk_idx <= ram_raddr;
    end
  end

  // Latch the command and accumulate sweep results
  always_ff @(posedge clk) begin
    if (rst) begin
      free_found <= 1'b0;
      old_seen   <= 1'b0;
      hit        <= 1'b0;
      close_cnt  <= '0;
    end else if (cmd_pop) begin
      free_found <= 1'b0;
      old_seen   <= 1'b0;
      hit        <= 1'b0;
      close_cnt  <= '0;
    end else if (state == ST_SWEEP) begin
      if (take_free) begin
        free_found <= 1'b1;
      end
      if (older) begin
        old_seen <= 1'b1;
      end
      if (close) begin
        hit <= 1'b1;
      end
      if ((close || free_up) && (close_cnt != 8'hFF)) begin
        close_cnt <= close_cnt + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur     <= cmd;
      free_idx <= '0;
      old_idx <= '0;
      hit_idx <= '0;
    end else if (state == ST_SWEEP) begin
      if (take_free) begin
        free_idx <= chk_idx;
      end
      if (older) begin
        old_idx   <= chk_idx;
        old_start <= e.start_ms;
      end
      if (close && (cur.op == hnst_pkg::OP_NOTE_OFF)) begin
        hit_idx <= chk_idx;
      end
    end
  end

  // Form the result beat
  always_comb begin
    slot_src  = (cur.op == hnst_pkg::OP_NOTE_ON) ? slot_pick :
                (cur.op == hnst_pkg::OP_NOTE_OFF) ? hit_idx : '0;
    slot_wide = {7'd0, slot_src};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res_slot   <= slot_wide[6:0];
      res_found  <= (cur.op == hnst_pkg::OP_NOTE_ON) ||
                    ((cur.op == hnst_pkg::OP_NOTE_OFF) && hit);
      res_stolen <= (cur.op == hnst_pkg::OP_NOTE_ON) && !free_found;
      res_count  <= close_cnt;
    end
  end

  assign empty        = !res_valid;
  assign slot         = res_slot;
  assign found        = res_found;
  assign stolen       = res_stolen;
  assign closed_count = res_count;

  // Checks
  `HNST_ASSERT_IMP(a_clear_no_pop, clk, rst, state == ST_CLEAR, !cmd_pop, "command taken during clear")
  `HNST_ASSERT_IMP(a_sweep_write_checked, clk, rst, (state == ST_SWEEP) && ram_we, chk_valid, "sweep write without checked entry")
  `HNST_ASSERT_NEXT(a_done_loads, clk, rst, (state == ST_DONE) && !res_valid, res_valid, "result not loaded from done")
  `HNST_ASSERT_IMP(a_steal_has_victim, clk, rst, (state == ST_COMMIT) && !free_found, old_seen, "steal with no active entry")

endmodule

`default_nettype wire

@@ sv/held_note_slot_table_top.sv @@
// Top level of the held note slot table: front end, back end and configuration port.
// Depends on hnst_pkg, hnst_front and hnst_back.
//
//   channel   handshake            payload
//   input     push / full          action, port, channel, note_number, now_ms
//   result    pop / empty          slot, found, stolen, closed_count
//   config    cfg_write            cfg_data (display duration)
//
// A note on passes through the back end in order: command pop, a sweep of all NOTE_SLOTS
// entries through the slot RAM read port, commit and result.
// Other events skip the commit; an unknown action goes from command pop straight to the result.
// After rst the back end clears the RAM, one entry a cycle, over all NOTE_SLOTS entries; full is
// held high during that pass.
// A two-beat command queue takes new events while the back end works or a result waits.
// A result not popped holds the back end in its final step; the queue then fills and full rises.
`default_nettype none

module held_note_slot_table_top #(
  parameter int NOTE_SLOTS = hnst_pkg::DEFAULT_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  port,
  input  wire logic [3:0]  channel,
  input  wire logic [6:0]  note_number,
  input  wire logic [31:0] now_ms,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [6:0]  slot,
  output      logic        found,
  output      logic        stolen,
  output      logic [7:0]  closed_count,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data
);

  logic                   cmd_valid;
  logic                   cmd_pop;
  hnst_pkg::cmd_t         cmd;
  hnst_pkg::back_status_t status;

  // Accept and classify events
  hnst_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .port        (port),
    .channel     (channel),
    .note_number (note_number),
    .now_ms      (now_ms),
    .status      (status),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // Sweep the table and deliver results
  hnst_back #(
    .NOTE_SLOTS (NOTE_SLOTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .status       (status),
    .empty        (empty),
    .pop          (pop),
    .slot         (slot),
    .found        (found),
    .stolen       (stolen),
    .closed_count (closed_count)
  );

endmodule

`default_nettype wire

@@ bench/tb_held_note_slot_table_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for held_note_slot_table_top: directed, full-table, back-pressure and
// random phases against a cycle-free slot table predictor. Needs hnst_pkg and the RTL only.

module tb_held_note_slot_table_top;

  localparam int SLOTS       = hnst_pkg::DEFAULT_SLOTS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 1500;
  localparam int REPORT_CAP  = 100;

  // Event codes the block has no meaning for
  localparam logic [2:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] ACT_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  port;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [31:0] now;
  } note_event_t;

  typedef struct packed {
    logic [6:0] slot;
    logic       found;
    logic       stolen;
    logic [7:0] closed_count;
  } slot_result_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        push         = 1'b0;
  logic        full;
  logic [2:0]  action       = '0;
  logic [7:0]  port         = '0;
  logic [3:0]  channel      = '0;
  logic [6:0]  note_number  = '0;
  logic [31:0] now_ms       = '0;
  logic        empty;
  logic        pop          = 1'b0;
  logic [6:0]  slot;
  logic        found;
  logic        stolen;
  logic [7:0]  closed_count;
  logic        cfg_write    = 1'b0;
  logic [15:0] cfg_data     = '0;

  held_note_slot_table_top dut (.*);

  always #4 clk = ~clk;

  // Predicted slot table and duration register
  logic        ent_active  [SLOTS];
  logic [7:0]  ent_port    [SLOTS];
  logic [3:0]  ent_channel [SLOTS];
  logic [6:0]  ent_note    [SLOTS];
  logic [31:0] ent_start   [SLOTS];
  logic [31:0] ent_end     [SLOTS];
  logic [15:0] duration_model;

  slot_result_t pending_results[$];

  // Run bookkeeping
  bit          idle_on     = 1'b1;
  logic        hold_req    = 1'b0;
  int          hold_left   = 0;
  int          rx_wait     = 0;
  int          cycle_count = 0;
  int          n_mismatch  = 0;
  int          n_results   = 0;
  int          n_events    = 0;
  int          n_steals    = 0;
  int          n_settings  = 0;
  int          max_closed  = 0;
  int          n_by_action [8];

  // Random stimulus knobs, set per phase
  logic [31:0] t_cursor   = 32'h0000_4000;
  int          t_step_max = 100;
  logic [7:0]  key_port   = '0;
  logic [3:0]  key_chan   = '0;
  logic [6:0]  key_note   = '0;

  function automatic logic entry_held(int i);
    return ent_active[i] && ent_end[i] == '0;
  endfunction

  function automatic logic entry_stale(int i, logic [31:0] t);
    logic [31:0] age;
    age = t - ent_end[i];
    return ent_active[i] && ent_end[i] != '0 && age > {16'd0, duration_model};
  endfunction

  function automatic logic same_chan(int i, note_event_t ev);
    return ent_port[i] == ev.port && ent_channel[i] == ev.channel;
  endfunction

  // Apply one event to the predicted table and return the result it produces
  function automatic slot_result_t slot_table_step(note_event_t ev);
    slot_result_t r;
    int           count;
    int           pick;
    logic         hit;
    logic         seen;
    r     = '0;
    count = 0;
    pick  = 0;
    hit   = 1'b0;
    seen  = 1'b0;
    case (ev.action)
      hnst_pkg::ACT_NOTE_ON: begin
        // close held notes with the same key first
        for (int i = 0; i < SLOTS; i++) begin
          if (entry_held(i) && same_chan(i, ev) && ent_note[i] == ev.note) begin
            ent_end[i] = ev.now;
            count++;
          end
        end
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (!ent_active[i] || entry_stale(i, ev.now)) begin
            pick = i;
            hit  = 1'b1;
          end
        end
        // no room: take the oldest start time, lowest slot on a tie
        if (!hit) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (ent_active[i] && (!seen || ent_start[i] < ent_start[pick])) begin
              pick = i;
              seen = 1'b1;
            end
          end
          r.stolen = 1'b1;
        end
        r.found           = 1'b1;
        r.slot            = pick[6:0];
        ent_active[pick]  = 1'b1;
        ent_port[pick]    = ev.port;
        ent_channel[pick] = ev.channel;
        ent_note[pick]    = ev.note;
        ent_start[pick]   = ev.now;
        ent_end[pick]     = '0;
      end
      hnst_pkg::ACT_NOTE_OFF: begin
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (entry_held(i) && same_chan(i, ev) && ent_note[i] == ev.note) begin
            ent_end[i] = ev.now;
            r.slot     = i[6:0];
            r.found    = 1'b1;
            hit        = 1'b1;
            count      = 1;
          end
        end
      end
      hnst_pkg::ACT_ALL_OFF, hnst_pkg::ACT_CHAN_OFF: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (entry_held(i) && (ev.action == hnst_pkg::ACT_ALL_OFF || same_chan(i, ev))) begin
            ent_end[i] = ev.now;
            count++;
          end
        end
      end
      hnst_pkg::ACT_EXPIRE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (entry_stale(i, ev.now)) begin
            ent_active[i] = 1'b0;
            count++;
          end
        end
      end
      default: begin
      end
    endcase
    r.closed_count = (count > 255) ? 8'd255 : count[7:0];
    return r;
  endfunction

  function automatic note_event_t event_of(logic [2:0] act, logic [7:0] p, logic [3:0] ch,
                                           logic [6:0] n, logic [31:0] t);
    note_event_t ev;
    ev.action  = act;
    ev.port    = p;
    ev.channel = ch;
    ev.note    = n;
    ev.now     = t;
    return ev;
  endfunction

  // Draw one event: mostly keys near the phase key, time moving forward by small steps
  function automatic note_event_t random_event();
    note_event_t ev;
    int          pick;
    logic [31:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.action = hnst_pkg::ACT_NOTE_ON;
    end else if (pick < 73) begin
      ev.action = hnst_pkg::ACT_NOTE_OFF;
    end else if (pick < 78) begin
      ev.action = hnst_pkg::ACT_CHAN_OFF;
    end else if (pick < 81) begin
      ev.action = hnst_pkg::ACT_ALL_OFF;
    end else if (pick < 95) begin
      ev.action = hnst_pkg::ACT_EXPIRE;
    end else begin
      r = $urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI);
      ev.action = r[2:0];
    end
    r = $urandom();
    if ($urandom_range(0, 9) == 0) begin
      ev.port    = r[7:0];
      ev.channel = r[11:8];
      ev.note    = r[18:12];
    end else begin
      ev.port    = key_port ^ {7'd0, r[0]};
      ev.channel = key_chan ^ {3'd0, r[1]};
      ev.note    = key_note + {4'd0, r[4:2]};
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      ev.now = '0;
    end else begin
      if (pick < 4) begin
        t_cursor = $urandom();
      end else if (pick < 5) begin
        r = $urandom_range(0, 4 * t_step_max);
        t_cursor = 32'hFFFF_FFFF - r;
      end else begin
        r = $urandom_range(0, t_step_max);
        t_cursor = t_cursor + r;
      end
      ev.now = t_cursor;
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_mismatch++;
    if (n_mismatch <= REPORT_CAP) begin
      $display("[%0t] result %0d: %s got %0d, expected %0d", $time, n_results, what, got,
               want);
    end
  endtask

  // Offer one event, after a random gap when idle_on is set, and hold it until the beat is taken
  task automatic send_event(input note_event_t ev);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    action      <= ev.action;
    port        <= ev.port;
    channel     <= ev.channel;
    note_number <= ev.note;
    now_ms      <= ev.now;
    do @(posedge clk); while (full !== 1'b0);
    pending_results.push_back(slot_table_step(ev));
    n_events++;
    n_by_action[ev.action]++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_duration(input logic [15:0] value);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    duration_model = value;
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  // Field extremes, every event kind, wrap of the release age, close at time zero
  task automatic test_directed();
    idle_on = 1'b1;
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'hFF, 4'hF, 7'h7F, 32'd0));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'hFF, 4'hF, 7'h7F, 32'd100));
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'hFF, 4'hF, 7'h7F, 32'd200));
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'hFF, 4'hF, 7'h7F, 32'd300));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'h00, 4'h0, 7'h00, 32'd0));
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'h00, 4'h0, 7'h00, 32'd0));
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'h00, 4'h0, 7'h00, 32'd0));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'h01, 4'h2, 7'h03, 32'hFFFF_FF00));
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'h01, 4'h2, 7'h03, 32'hFFFF_FF00));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'h01, 4'h2, 7'h04, 32'h0000_0B00));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'h01, 4'h2, 7'h05, 32'h0000_0B00));
    send_event(event_of(hnst_pkg::ACT_CHAN_OFF, 8'h01, 4'h2, 7'h00, 32'h0000_0C00));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON,  8'h07, 4'h9, 7'h40, 32'hFFFF_FFFF));
    send_event(event_of(hnst_pkg::ACT_ALL_OFF,  8'h00, 4'h0, 7'h00, 32'h0000_0D00));
    send_event(event_of(hnst_pkg::ACT_EXPIRE,   8'hFF, 4'hF, 7'h7F, 32'h0000_0D00));
    send_event(event_of(hnst_pkg::ACT_EXPIRE,   8'h00, 4'h0, 7'h00, 32'h0000_0D00));
    for (int a = int'(ACT_UNKNOWN_LO); a <= int'(ACT_UNKNOWN_HI); a++) begin
      send_event(event_of(a[2:0], 8'hFF, 4'hF, 7'h7F, 32'hFFFF_FFFF));
    end
    send_event(event_of(hnst_pkg::ACT_NOTE_OFF, 8'h55, 4'hA, 7'h2A, 32'hFFFF_FFFF));
    send_event(event_of(hnst_pkg::ACT_CHAN_OFF, 8'hAA, 4'h5, 7'h55, 32'd0));
  endtask

  // Empty the table, fill every slot with held notes across a time wrap, then steal
  task automatic test_full_table();
    logic [31:0] base;
    idle_on = 1'b1;
    write_duration(16'd0);
    base = 32'h0001_0000;
    send_event(event_of(hnst_pkg::ACT_ALL_OFF, 8'h00, 4'h0, 7'h00, base));
    send_event(event_of(hnst_pkg::ACT_EXPIRE,  8'h00, 4'h0, 7'h00, base + 32'd1));
    write_duration(16'hFFFF);
    // start times tie in groups of eight and wrap through zero
    for (int i = 0; i < SLOTS; i++) begin
      send_event(event_of(hnst_pkg::ACT_NOTE_ON, i[7:0], i[3:0], i[6:0],
                          32'hFFFF_FFF4 + i / 8));
    end
    send_event(event_of(hnst_pkg::ACT_NOTE_ON, 8'hC0, 4'h1, 7'h11, 32'h0000_0010));
    send_event(event_of(hnst_pkg::ACT_NOTE_ON, 8'hC1, 4'h2, 7'h22, 32'h0000_0011));
    send_event(event_of(hnst_pkg::ACT_ALL_OFF, 8'h00, 4'h0, 7'h00, 32'h0000_0100));
    send_event(event_of(hnst_pkg::ACT_EXPIRE,  8'h00, 4'h0, 7'h00, 32'h0000_0200));
  endtask

  // Hold off the receiver while the sender keeps offering, so full rises
  task automatic test_backpressure();
    wait_drained();
    idle_on    = 1'b0;
    t_step_max = 50;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (40) send_event(random_event());
    idle_on = 1'b1;
  endtask

  task automatic run_random_phase(input logic [15:0] dur, input int step_max, input int n_items,
                                  input bit idle);
    logic [31:0] r;
    write_duration(dur);
    idle_on    = idle;
    t_step_max = step_max;
    r          = $urandom();
    key_port   = r[7:0];
    key_chan   = r[11:8];
    key_note   = r[18:12];
    repeat (n_items) send_event(random_event());
  endtask

  task automatic test_random();
    logic [15:0] dur;
    run_random_phase(16'd3000, 100, 250, 1'b1);
    run_random_phase(16'd0, 2, 200, 1'b1);
    run_random_phase(16'hFFFF, 20, 300, 1'b0);
    run_random_phase(16'd1, 3, 150, 1'b1);
    dur = 16'($urandom_range(0, 16'hFFFF));
    run_random_phase(dur, int'(dur) / 16 + 3, 200, 1'b1);
    run_random_phase(16'd3000, 400, 150, 1'b1);
  endtask

  // Count the long receiver hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result beat against the oldest prediction, then pace pop
  always @(posedge clk) begin : result_check
    slot_result_t want;
    int           gap;
    if (rst) begin
      pop     <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (pop && !empty) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, slot", 32'(slot), 0);
        end else begin
          want = pending_results.pop_front();
          if (slot !== want.slot) report_mismatch("slot", 32'(slot), 32'(want.slot));
          if (found !== want.found) report_mismatch("found", 32'(found), 32'(want.found));
          if (stolen !== want.stolen) begin
            report_mismatch("stolen", 32'(stolen), 32'(want.stolen));
          end
          if (closed_count !== want.closed_count) begin
            report_mismatch("closed_count", 32'(closed_count), 32'(want.closed_count));
          end
        end
        if (stolen === 1'b1) n_steals++;
        if (int'(closed_count) > max_closed) max_closed = int'(closed_count);
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (pop && !empty) begin
        gap = idle_on ? $urandom_range(0, 7) : 0;
        pop     <= (gap == 0);
        rx_wait <= (gap == 0) ? 0 : gap - 1;
      end else if (!pop) begin
        if (rx_wait == 0) begin
          pop <= 1'b1;
        end else begin
          rx_wait <= rx_wait - 1;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      ent_active[i]  = 1'b0;
      ent_port[i]    = '0;
      ent_channel[i] = '0;
      ent_note[i]    = '0;
      ent_start[i]   = '0;
      ent_end[i]     = '0;
    end
    for (int i = 0; i < 8; i++) n_by_action[i] = 0;
    duration_model = hnst_pkg::DEFAULT_DURATION;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_backpressure();
    test_random();

    // let any stray beat show up before closing
    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Covered %0d events (on %0d, off %0d, all off %0d, channel off %0d, expire %0d)",
             n_events, n_by_action[hnst_pkg::ACT_NOTE_ON],
             n_by_action[hnst_pkg::ACT_NOTE_OFF], n_by_action[hnst_pkg::ACT_ALL_OFF],
             n_by_action[hnst_pkg::ACT_CHAN_OFF], n_by_action[hnst_pkg::ACT_EXPIRE]);
    $display("Checked %0d results over %0d duration writes; %0d steals, largest close count %0d",
             n_results, n_settings, n_steals, max_closed);
    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("FAIL");
    end
    $finish;
  end

endmodule
